// ===== rtl/core/byte_ring_buffer_assert.svh =====
// Assertion helpers for the ring buffer RTL (included by brb_back); clock i_clk, reset i_rst_n.
`ifndef BYTE_RING_BUFFER_ASSERT_SVH
`define BYTE_RING_BUFFER_ASSERT_SVH

// Condition holds at every edge outside reset.
`define BRB_ASSERT_HOLDS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("brb: invariant violated");

// Consequent holds in the cycle after the antecedent.
`define BRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brb: sequence violated");

`endif

// ===== rtl/core/brb_pkg.sv =====
package brb_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int MODE_W    = 3;
    localparam int DATA_W    = 8;
    localparam int CNT_W     = 9;
    localparam int STAT_W    = 2;

    localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

    localparam logic [MODE_W-1:0] MODE_PUSH_OVER   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_STRICT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK        = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADVANCE     = 3'd4;

    typedef enum logic [2:0] {
        OP_PUSH_OVER   = 3'd0,
        OP_PUSH_STRICT = 3'd1,
        OP_POP         = 3'd2,
        OP_PEEK        = 3'd3,
        OP_ADVANCE     = 3'd4,
        OP_NONE        = 3'd5
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  amount;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        t_status           status;
        logic [CNT_W-1:0]  advanced;
        logic [CNT_W-1:0]  fill_level;
    } t_res;

endpackage

// ===== rtl/core/brb_in_if.sv =====
interface brb_in_if;
    logic                         valid;
    logic                         ready;
    logic [brb_pkg::MODE_W-1:0]   mode;
    logic [brb_pkg::DATA_W-1:0]   data;
    logic [brb_pkg::CNT_W-1:0]    amount;

    modport source (output valid, output mode, output data, output amount, input ready);
    modport sink   (input valid, input mode, input data, input amount, output ready);
endinterface

// ===== rtl/core/brb_out_if.sv =====
interface brb_out_if;
    logic                         valid;
    logic                         ready;
    logic [brb_pkg::DATA_W-1:0]   read_data;
    logic [brb_pkg::STAT_W-1:0]   status;
    logic [brb_pkg::CNT_W-1:0]    advanced;
    logic [brb_pkg::CNT_W-1:0]    fill_level;

    modport source (output valid, output read_data, output status, output advanced,
                    output fill_level, input ready);
    modport sink   (input valid, input read_data, input status, input advanced,
                    input fill_level, output ready);
endinterface

// ===== rtl/core/byte_ring_buffer.sv =====
// Byte ring buffer: command queue in front, ring store and pointer logic behind.
// Path: a command is stored in the command queue, issued to the back end and its result registered;
// a pop or peek that reads first waits in S_RDATA for the registered read of the byte store.
// Throughput: one operation per cycle while o_out.ready allows and no read is waiting in S_RDATA.
// Reset (synchronous, active low): ring empty, capacity 256, store contents kept.
module byte_ring_buffer #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [brb_pkg::CNT_W-1:0]   i_cfg_wr_data,
    brb_in_if.sink                      i_in,
    brb_out_if.source                   o_out
);

    logic           q_push, q_full, q_pop, q_valid;
    brb_pkg::t_cmd  q_wcmd, q_rcmd;

    brb_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_cmd    (q_wcmd)
    );

    brb_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_wcmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_rcmd)
    );

    brb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_rcmd),
        .o_cmd_pop     (q_pop),
        .o_out         (o_out)
    );

endmodule

// ===== rtl/core/brb_front.sv =====
module brb_front (
    brb_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_q_push,
    output brb_pkg::t_cmd   o_cmd
);

    assign i_in.ready = !i_q_full;
    assign o_q_push   = i_in.valid && !i_q_full;

    always_comb begin
        o_cmd.data   = i_in.data;
        o_cmd.amount = i_in.amount;
        case (i_in.mode)
            brb_pkg::MODE_PUSH_OVER:   o_cmd.op = brb_pkg::OP_PUSH_OVER;
            brb_pkg::MODE_PUSH_STRICT: o_cmd.op = brb_pkg::OP_PUSH_STRICT;
            brb_pkg::MODE_POP:         o_cmd.op = brb_pkg::OP_POP;
            brb_pkg::MODE_PEEK:        o_cmd.op = brb_pkg::OP_PEEK;
            brb_pkg::MODE_ADVANCE:     o_cmd.op = brb_pkg::OP_ADVANCE;
            default:                   o_cmd.op = brb_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== rtl/core/brb_cmdq.sv =====
module brb_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  brb_pkg::t_cmd   i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output brb_pkg::t_cmd   o_cmd
);

    localparam int QD    = 2;
    localparam int QP_W  = $clog2(QD);
    localparam int QC_W  = $clog2(QD + 1);

    brb_pkg::t_cmd      r_ent [QD];
    logic [QP_W-1:0]    r_wp;
    logic [QP_W-1:0]    r_rp;
    logic [QC_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == QC_W'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_ent[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QP_W'(QD - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QP_W'(QD - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/brb_back.sv =====
`include "byte_ring_buffer_assert.svh"

module brb_back #(
    parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [brb_pkg::CNT_W-1:0]   i_cfg_wr_data,
    input  logic                        i_cmd_valid,
    input  brb_pkg::t_cmd               i_cmd,
    output logic                        o_cmd_pop,
    brb_out_if.source                   o_out
);

    localparam int CNT_W   = brb_pkg::CNT_W;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CW      = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam int CAP_MAX = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

    typedef enum logic [1:0] {
        S_EXEC  = 2'b01,
        S_RDATA = 2'b10
    } t_bstate;

    t_bstate                        r_state;
    logic [CNT_W-1:0]               r_cap;
    logic [PTR_W-1:0]               r_head, n_head;
    logic [PTR_W-1:0]               r_tail, n_tail;
    logic [CNT_W-1:0]               r_held, n_held;
    logic                           r_out_valid;
    brb_pkg::t_res                  r_out;
    brb_pkg::t_res                  r_pend;
    logic [brb_pkg::DATA_W-1:0]     r_rdata;
    logic [brb_pkg::DATA_W-1:0]     r_mem [DEPTH];

    logic [CNT_W-1:0]   ecap;
    logic [CW-1:0]      cap_w, head_w, tail_w, head_inc_w, tail_inc_w, sum_w, wrap_w, ring_end;
    logic [PTR_W-1:0]   head_inc, tail_inc, head_off;
    logic [CNT_W-1:0]   adv_clamp, off;
    logic               full, out_free, issue, need_rd;
    logic               mem_we, mem_re;
    logic [PTR_W-1:0]   mem_raddr;
    brb_pkg::t_res      res;

    // effective capacity saturates to 1..CAP_MAX (DEPTH, but at most 511)
    always_comb begin
        if (r_cap == '0) begin
            ecap = CNT_W'(1);
        end else if (r_cap > CNT_W'(CAP_MAX)) begin
            ecap = CNT_W'(CAP_MAX);
        end else begin
            ecap = r_cap;
        end
    end

    always_comb begin
        cap_w      = CW'(ecap);
        head_w     = CW'(r_head);
        tail_w     = CW'(r_tail);
        head_inc_w = head_w + CW'(1);
        tail_inc_w = tail_w + CW'(1);
        head_inc   = (head_inc_w == cap_w) ? '0 : head_inc_w[PTR_W-1:0];
        tail_inc   = (tail_inc_w == cap_w) ? '0 : tail_inc_w[PTR_W-1:0];
        adv_clamp  = (i_cmd.amount < r_held) ? i_cmd.amount : r_held;
        off        = (i_cmd.op == brb_pkg::OP_PEEK) ? i_cmd.amount : adv_clamp;
        // head plus an offset no larger than the capacity needs one subtract to wrap
        sum_w      = head_w + CW'(off);
        wrap_w     = (sum_w >= cap_w) ? sum_w - cap_w : sum_w;
        head_off   = wrap_w[PTR_W-1:0];
        ring_end   = (head_w + CW'(r_held) >= cap_w) ? head_w + CW'(r_held) - cap_w
                                                      : head_w + CW'(r_held);
        full       = (r_held == ecap);
        out_free   = !r_out_valid || o_out.ready;
        issue      = (r_state == S_EXEC) && i_cmd_valid && out_free;
    end

    assign o_cmd_pop = issue;

    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_held         = r_held;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = r_head;
        need_rd        = 1'b0;
        res.read_data  = '0;
        res.status     = brb_pkg::ST_OK;
        res.advanced   = '0;
        if (issue) begin
            case (i_cmd.op)
                brb_pkg::OP_PUSH_OVER: begin
                    mem_we = 1'b1;
                    if (full) begin
                        n_head = head_inc;
                    end else begin
                        n_held = r_held + 1'b1;
                    end
                    n_tail       = tail_inc;
                    res.advanced = CNT_W'(1);
                end
                brb_pkg::OP_PUSH_STRICT: begin
                    if (full) begin
                        res.status = brb_pkg::ST_FULL;
                    end else begin
                        mem_we       = 1'b1;
                        n_tail       = tail_inc;
                        n_held       = r_held + 1'b1;
                        res.advanced = CNT_W'(1);
                    end
                end
                brb_pkg::OP_POP: begin
                    if (r_held == '0) begin
                        res.status = brb_pkg::ST_EMPTY;
                    end else begin
                        mem_re       = 1'b1;
                        need_rd      = 1'b1;
                        n_head       = head_inc;
                        n_held       = r_held - 1'b1;
                        res.advanced = CNT_W'(1);
                    end
                end
                brb_pkg::OP_PEEK: begin
                    if (i_cmd.amount >= r_held) begin
                        res.status = brb_pkg::ST_EMPTY;
                    end else begin
                        mem_re    = 1'b1;
                        need_rd   = 1'b1;
                        mem_raddr = head_off;
                    end
                end
                brb_pkg::OP_ADVANCE: begin
                    if (r_held == '0) begin
                        res.status = brb_pkg::ST_EMPTY;
                    end else begin
                        res.advanced = adv_clamp;
                        n_held       = r_held - adv_clamp;
                        n_head       = head_off;
                    end
                end
                default: begin
                end
            endcase
        end
        res.fill_level = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EXEC;
            r_cap       <= brb_pkg::CAP_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a capacity write also empties the ring
            if (i_cfg_wr_en) begin
                r_cap  <= i_cfg_wr_data;
                r_head <= '0;
                r_tail <= '0;
                r_held <= '0;
            end else begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_held <= n_held;
            end
            if (issue && need_rd) begin
                r_state <= S_RDATA;
            end else if ((r_state == S_RDATA) && out_free) begin
                r_state <= S_EXEC;
            end
            if ((issue && !need_rd) || ((r_state == S_RDATA) && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue && need_rd) begin
            r_pend <= res;
        end
        if (issue && !need_rd) begin
            r_out <= res;
        end else if ((r_state == S_RDATA) && out_free) begin
            r_out <= {r_rdata, r_pend.status, r_pend.advanced, r_pend.fill_level};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_tail] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out.read_data;
    assign o_out.status     = r_out.status;
    assign o_out.advanced   = r_out.advanced;
    assign o_out.fill_level = r_out.fill_level;

    `BRB_ASSERT_HOLDS(a_held_le_cap, r_held <= ecap)
    `BRB_ASSERT_HOLDS(a_ptr_in_range, (head_w < cap_w) && (tail_w < cap_w))
    `BRB_ASSERT_HOLDS(a_ring_consistent, ring_end == tail_w)
    `BRB_ASSERT_NEXT(a_read_wait, issue && need_rd, r_state == S_RDATA)

endmodule
